FILE: sv/vox_pkg.sv
package vox_pkg;

   // Grid size: the coordinate fields and the entry index follow from these.
   localparam int GRID_X_BITS = 5;
   localparam int GRID_Y_BITS = 5;
   localparam int GRID_Z_BITS = 3;
   localparam int IDX_BITS    = GRID_X_BITS + GRID_Y_BITS + GRID_Z_BITS;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [GRID_X_BITS-1:0] voxel_x;
      logic [GRID_Y_BITS-1:0] voxel_y;
      logic [GRID_Z_BITS-1:0] voxel_z;
      logic [31:0] stamp_ticks;
      logic [15:0] view_id;
   } req_word_type;

   typedef struct packed {
      logic        known;
      logic        occupied;
      logic        free_flag;
      logic        dyn_suspect;
      logic        static_cand;
      logic signed [15:0] log_odds_out;
      logic [15:0] hit_total;
      logic [15:0] miss_total;
   } rsp_word_type;

   typedef enum logic [1:0] {
      REQ_HIT   = 2'd0,
      REQ_MISS  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_SPARE = 2'd3
   } req_code_type;

   localparam logic [2:0] CSR_HIT_INC   = 3'd0;
   localparam logic [2:0] CSR_MISS_INC  = 3'd1;
   localparam logic [2:0] CSR_OCC_THR   = 3'd2;
   localparam logic [2:0] CSR_FREE_THR  = 3'd3;
   localparam logic [2:0] CSR_FLOOR     = 3'd4;
   localparam logic [2:0] CSR_CEILING   = 3'd5;
   localparam logic [2:0] CSR_MIN_HITS  = 3'd6;
   localparam logic [2:0] CSR_MIN_LIFE  = 3'd7;

   typedef struct packed {
      logic signed [15:0] hit_inc;
      logic signed [15:0] miss_inc;
      logic signed [15:0] occ_thr;
      logic signed [15:0] free_thr;
      logic signed [15:0] floor_lo;
      logic signed [15:0] ceil_hi;
      logic [15:0]        min_hits;
      logic [31:0]        min_life;
   } cfg_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic clear;     // clear one valid bit of the clearing pass
      logic capture;   // latch request and issue store read
      logic compute;   // read data is back: work out the new entry
      logic commit;    // write entry and load result register
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage

FILE: sv/vox_ctrl.sv
module vox_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  vox_pkg::sts_type sts,
   output vox_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_READ    = 5'b00100,
      ST_COMPUTE = 5'b01000,
      ST_COMMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   // A new word may enter while the previous result still waits, as long as
   // it is gone by the time this one commits.
   assign take      = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPUTE;
         end
         ST_COMPUTE: begin
            cmd.compute = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/vox_datapath.sv
module vox_datapath #(
   parameter int MIN_VIEW_COUNT      = 2,
   parameter int CLEAR_RATIO_PERCENT = 70,
   parameter int DYNAMIC_FILTER_ON   = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vox_pkg::cmd_type      cmd,
   output vox_pkg::sts_type      sts,
   input  vox_pkg::cfg_type      cfg,
   input  vox_pkg::req_word_type req_word,
   output vox_pkg::rsp_word_type rsp_word
);

   localparam int IDX_BITS = vox_pkg::IDX_BITS;
   localparam int DEPTH    = 1 << IDX_BITS;
   localparam logic [IDX_BITS-1:0] IDX_ONE = {{(IDX_BITS-1){1'b0}}, 1'b1};

   typedef struct packed {
      logic signed [15:0] lo;
      logic [15:0] hits;
      logic [15:0] misses;
      logic [15:0] views;
      logic [15:0] last_view;
      logic [31:0] first_seen;
      logic [31:0] last_seen;
      logic [31:0] last_hit;
      logic [31:0] last_miss;
      logic [3:0]  flags;
   } entry_type;

   entry_type mem [DEPTH];
   entry_type rd_ff;
   entry_type upd_ff, upd_in;

   // One valid bit per voxel, kept in a memory of its own and cleared one
   // address a cycle by the pass that follows reset.
   logic                  valid_mem [DEPTH];
   logic                  valid_ff;
   logic [IDX_BITS-1:0]   clr_ff;

   vox_pkg::req_word_type rq_ff;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  upd_req;
   logic                  known_ff;

   always_comb begin
      idx_in = {req_word.voxel_z, req_word.voxel_y, req_word.voxel_x};
   end

   assign upd_req        = (rq_ff.req_type == vox_pkg::REQ_HIT) ||
                           (rq_ff.req_type == vox_pkg::REQ_MISS);
   assign sts.clear_done = (clr_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + IDX_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rq_ff    <= req_word;
         idx_ff   <= idx_in;
         rd_ff    <= mem[idx_in];
         valid_ff <= valid_mem[idx_in];
      end
      if (cmd.commit && upd_req) begin
         mem[idx_ff] <= upd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         valid_mem[clr_ff] <= 1'b0;
      end else if (cmd.commit && upd_req) begin
         valid_mem[idx_ff] <= 1'b1;
      end
   end

   // Compute stage: the new entry and its classification.
   logic signed [16:0] sum;
   logic signed [15:0] inc, lo_c;
   logic [31:0]        life;
   logic [18:0]        total;
   logic [24:0]        lhs, rhs;
   logic               ratio_ok, occ, fre, dyn, stat;
   entry_type          base;

   always_comb begin
      base = rd_ff;
      if (!valid_ff) begin
         base.lo        = '0;
         base.hits      = '0;
         base.misses    = '0;
         base.views     = 16'd1;
         base.last_view = rq_ff.view_id;
         base.last_hit  = '0;
         base.last_miss = '0;
      end else if (rd_ff.last_view != rq_ff.view_id) begin
         if (rd_ff.views != 16'hFFFF) base.views = rd_ff.views + 16'd1;
         base.last_view = rq_ff.view_id;
      end
      upd_in = base;
      if (base.hits == 16'd0 && base.misses == 16'd0) upd_in.first_seen = rq_ff.stamp_ticks;
      upd_in.last_seen = rq_ff.stamp_ticks;
      inc = (rq_ff.req_type == vox_pkg::REQ_HIT) ? cfg.hit_inc : cfg.miss_inc;
      sum = 17'(base.lo) + 17'(inc);
      if (sum < 17'(cfg.floor_lo)) sum = 17'(cfg.floor_lo);
      if (sum > 17'(cfg.ceil_hi))  sum = 17'(cfg.ceil_hi);
      lo_c = sum[15:0];
      upd_in.lo = lo_c;
      if (rq_ff.req_type == vox_pkg::REQ_HIT) begin
         if (base.hits != 16'hFFFF) upd_in.hits = base.hits + 16'd1;
         upd_in.last_hit = rq_ff.stamp_ticks;
      end else begin
         if (base.misses != 16'hFFFF) upd_in.misses = base.misses + 16'd1;
         upd_in.last_miss = rq_ff.stamp_ticks;
      end
      occ  = lo_c >= cfg.occ_thr;
      fre  = lo_c <= cfg.free_thr;
      life = (upd_in.last_seen >= upd_in.first_seen) ?
             upd_in.last_seen - upd_in.first_seen : 32'd0;
      total = 19'(upd_in.hits) + 19'(upd_in.misses);
      lhs   = 25'(upd_in.misses) * 25'd100;
      rhs   = 25'(total) * 25'(CLEAR_RATIO_PERCENT);
      ratio_ok = (total == 19'd0) ? (CLEAR_RATIO_PERCENT <= 0) : (lhs >= rhs);
      dyn  = (DYNAMIC_FILTER_ON != 0) && (upd_in.hits < cfg.min_hits) && ratio_ok &&
             (upd_in.last_miss > upd_in.last_hit);
      stat = occ && !dyn && (upd_in.hits >= cfg.min_hits) &&
             (32'(upd_in.views) >= 32'(MIN_VIEW_COUNT)) && (life >= cfg.min_life);
      upd_in.flags = {stat, dyn, fre, occ};
   end

   always_ff @(posedge clock) begin
      if (cmd.compute) begin
         upd_ff   <= upd_req ? upd_in : rd_ff;
         known_ff <= upd_req || valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (known_ff) begin
            rsp_word.known        <= 1'b1;
            rsp_word.occupied     <= upd_ff.flags[0];
            rsp_word.free_flag    <= upd_ff.flags[1];
            rsp_word.dyn_suspect  <= upd_ff.flags[2];
            rsp_word.static_cand  <= upd_ff.flags[3];
            rsp_word.log_odds_out <= upd_ff.lo;
            rsp_word.hit_total    <= upd_ff.hits;
            rsp_word.miss_total   <= upd_ff.misses;
         end else begin
            rsp_word <= '0;
         end
      end
   end

endmodule

FILE: sv/voxel_occupancy_update.sv
// The response word is registered: an accepted request passes the read, compute and commit
// states, and commit waits while an earlier result is stalled. One word is taken at a time;
// the entry is read, updated and written back to the store before the next word is taken.
// Reset (synchronous, active high) restores the register defaults and then runs a clearing
// pass over all 8192 voxels, one voxel a cycle, during which req_stall stays high.
module voxel_occupancy_update #(
   parameter int MIN_VIEW_COUNT      = 2,
   parameter int CLEAR_RATIO_PERCENT = 70,
   parameter int DYNAMIC_FILTER_ON   = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  vox_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output vox_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data
);

   vox_pkg::cfg_type cfg_ff;
   vox_pkg::cmd_type cmd;
   vox_pkg::sts_type sts;

   // Configuration registers. Each write keeps only the register's own width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hit_inc  <= 16'sd217;
         cfg_ff.miss_inc <= -16'sd103;
         cfg_ff.occ_thr  <= 16'sd0;
         cfg_ff.free_thr <= -16'sd256;
         cfg_ff.floor_lo <= -16'sd512;
         cfg_ff.ceil_hi  <= 16'sd896;
         cfg_ff.min_hits <= 16'd3;
         cfg_ff.min_life <= 32'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            vox_pkg::CSR_HIT_INC:  cfg_ff.hit_inc  <= csr_data[15:0];
            vox_pkg::CSR_MISS_INC: cfg_ff.miss_inc <= csr_data[15:0];
            vox_pkg::CSR_OCC_THR:  cfg_ff.occ_thr  <= csr_data[15:0];
            vox_pkg::CSR_FREE_THR: cfg_ff.free_thr <= csr_data[15:0];
            vox_pkg::CSR_FLOOR:    cfg_ff.floor_lo <= csr_data[15:0];
            vox_pkg::CSR_CEILING:  cfg_ff.ceil_hi  <= csr_data[15:0];
            vox_pkg::CSR_MIN_HITS: cfg_ff.min_hits <= csr_data[15:0];
            vox_pkg::CSR_MIN_LIFE: cfg_ff.min_life <= csr_data;
            default: ;
         endcase
      end
   end

   // The controller first walks the clearing pass, then sequences capture,
   // compute and commit for each word; the response register holds its word
   // while the far side stalls.
   vox_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vox_datapath #(
      .MIN_VIEW_COUNT      (MIN_VIEW_COUNT),
      .CLEAR_RATIO_PERCENT (CLEAR_RATIO_PERCENT),
      .DYNAMIC_FILTER_ON   (DYNAMIC_FILTER_ON)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .cfg      (cfg_ff),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

FILE: sv/vox_checker.sv
module vox_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input vox_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed under stall");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.known |-> rsp_word.hit_total == 16'd0 &&
      rsp_word.miss_total == 16'd0 && !rsp_word.occupied)
      else $error("unknown voxel reported state");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("not clearing after reset");

endmodule

bind voxel_occupancy_update vox_checker u_vox_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

FILE: tb/sv/tb_voxel_occupancy_update.sv
module tb_voxel_occupancy_update;

   // The grid holds 32 x 32 x 8 voxels; the index packs x, then y, then z.
   localparam int VOXEL_COUNT = 8192;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 12;
   localparam int CLEAR_PCT = 70;
   localparam int MIN_VIEWS = 2;
   localparam int HOLD_CYCLES = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   vox_pkg::req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   vox_pkg::rsp_word_type rsp_word;
   logic         csr_write = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   voxel_occupancy_update dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // The predictor's own copy of the settings and of every voxel.
   vox_pkg::cfg_type grid_cfg;
   bit          vox_known   [VOXEL_COUNT];
   logic signed [15:0] vox_odds [VOXEL_COUNT];
   logic [15:0] vox_hits    [VOXEL_COUNT];
   logic [15:0] vox_misses  [VOXEL_COUNT];
   logic [15:0] vox_views   [VOXEL_COUNT];
   logic [15:0] vox_view_id [VOXEL_COUNT];
   logic [31:0] vox_first   [VOXEL_COUNT];
   logic [31:0] vox_seen    [VOXEL_COUNT];
   logic [31:0] vox_hit_at  [VOXEL_COUNT];
   logic [31:0] vox_miss_at [VOXEL_COUNT];
   logic [3:0]  vox_flags   [VOXEL_COUNT];

   vox_pkg::rsp_word_type expected_words[$];
   int  error_count = 0;
   int  checked_count = 0;
   int  idle_cycles = 0;
   bit  quiet_mode = 1'b0;   // no idling on either side while set
   bit  hold_request = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_span = 0;

   // Applies one request word to the predicted grid and queues the result.
   task automatic predict_occupancy(input vox_pkg::req_word_type w);
      logic [12:0] idx;
      int  total;
      logic signed [17:0] sum;
      logic [15:0] h, m;
      logic [31:0] life;
      bit occ, fre, ratio, dyn, stat;
      vox_pkg::rsp_word_type r;
      idx = {w.voxel_z, w.voxel_y, w.voxel_x};
      if (w.req_type == vox_pkg::REQ_HIT || w.req_type == vox_pkg::REQ_MISS) begin
         if (!vox_known[idx]) begin
            vox_known[idx] = 1'b1;
            vox_odds[idx] = '0;
            vox_hits[idx] = '0;
            vox_misses[idx] = '0;
            vox_views[idx] = 16'd1;
            vox_view_id[idx] = w.view_id;
            vox_hit_at[idx] = '0;
            vox_miss_at[idx] = '0;
         end else if (vox_view_id[idx] != w.view_id) begin
            if (vox_views[idx] != 16'hFFFF) vox_views[idx] = vox_views[idx] + 16'd1;
            vox_view_id[idx] = w.view_id;
         end
         if (vox_hits[idx] == 0 && vox_misses[idx] == 0) vox_first[idx] = w.stamp_ticks;
         vox_seen[idx] = w.stamp_ticks;
         sum = 18'(vox_odds[idx]) + 18'((w.req_type == vox_pkg::REQ_HIT) ?
                                        grid_cfg.hit_inc : grid_cfg.miss_inc);
         if (sum < 18'(grid_cfg.floor_lo)) sum = 18'(grid_cfg.floor_lo);
         if (sum > 18'(grid_cfg.ceil_hi)) sum = 18'(grid_cfg.ceil_hi);
         vox_odds[idx] = sum[15:0];
         if (w.req_type == vox_pkg::REQ_HIT) begin
            if (vox_hits[idx] != 16'hFFFF) vox_hits[idx] = vox_hits[idx] + 16'd1;
            vox_hit_at[idx] = w.stamp_ticks;
         end else begin
            if (vox_misses[idx] != 16'hFFFF) vox_misses[idx] = vox_misses[idx] + 16'd1;
            vox_miss_at[idx] = w.stamp_ticks;
         end
         h = vox_hits[idx];
         m = vox_misses[idx];
         occ = vox_odds[idx] >= grid_cfg.occ_thr;
         fre = vox_odds[idx] <= grid_cfg.free_thr;
         life = (vox_seen[idx] >= vox_first[idx]) ? vox_seen[idx] - vox_first[idx] : 32'd0;
         total = int'(h) + int'(m);
         ratio = (total == 0) ? (CLEAR_PCT <= 0) : (int'(m) * 100 >= CLEAR_PCT * total);
         dyn = h < grid_cfg.min_hits && ratio && vox_miss_at[idx] > vox_hit_at[idx];
         stat = occ && !dyn && h >= grid_cfg.min_hits && vox_views[idx] >= MIN_VIEWS &&
                life >= grid_cfg.min_life;
         vox_flags[idx] = {stat, dyn, fre, occ};
      end
      r = '0;
      if (vox_known[idx]) begin
         r.known = 1'b1;
         {r.static_cand, r.dyn_suspect, r.free_flag, r.occupied} = vox_flags[idx];
         r.log_odds_out = vox_odds[idx];
         r.hit_total = vox_hits[idx];
         r.miss_total = vox_misses[idx];
      end
      expected_words = {expected_words, r};
   endtask

   // Offers one word, sometimes after a random gap, and waits until it is taken.
   // The valid line stays high after acceptance so that words can follow
   // back to back; a gap or a drain lowers it.
   task automatic send_word(input vox_pkg::req_word_type w);
      if (!quiet_mode && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!quiet_mode && $urandom_range(99) < 20);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      predict_occupancy(w);
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [4:0] x,
                              input logic [4:0] y, input logic [2:0] z,
                              input logic [31:0] stamp, input logic [15:0] view);
      vox_pkg::req_word_type w;
      w.req_type = kind;
      w.voxel_x = x;
      w.voxel_y = y;
      w.voxel_z = z;
      w.stamp_ticks = stamp;
      w.view_id = view;
      send_word(w);
   endtask

   // Waits for every outstanding result, then for the block to fall idle.
   task automatic drain_block();
      req_valid <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         vox_pkg::CSR_HIT_INC:  grid_cfg.hit_inc = value[15:0];
         vox_pkg::CSR_MISS_INC: grid_cfg.miss_inc = value[15:0];
         vox_pkg::CSR_OCC_THR:  grid_cfg.occ_thr = value[15:0];
         vox_pkg::CSR_FREE_THR: grid_cfg.free_thr = value[15:0];
         vox_pkg::CSR_FLOOR:    grid_cfg.floor_lo = value[15:0];
         vox_pkg::CSR_CEILING:  grid_cfg.ceil_hi = value[15:0];
         vox_pkg::CSR_MIN_HITS: grid_cfg.min_hits = value[15:0];
         default:               grid_cfg.min_life = value;
      endcase
      @(posedge clock);
   endtask

   task automatic random_word(input int pool);
      logic [1:0] kind;
      int v;
      v = $urandom_range(99);
      kind = (v < 45) ? vox_pkg::REQ_HIT : (v < 85) ? vox_pkg::REQ_MISS :
             (v < 95) ? vox_pkg::REQ_QUERY : vox_pkg::REQ_SPARE;
      // A small pool of voxels makes the same entries come back often, so
      // words to one voxel follow each other closely.
      send_fields(kind, 5'($urandom_range(pool)), 5'($urandom_range(1)),
                  3'($urandom_range(7)),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(3000),
                  16'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)));
   endtask

   // Extremes of the fields, every request code, unknown voxels and time wrap.
   task automatic test_directed_cases();
      send_fields(vox_pkg::REQ_QUERY, 5'd0, 5'd0, 3'd0, 32'd0, 16'd0);
      send_fields(vox_pkg::REQ_SPARE, 5'd31, 5'd31, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
      send_fields(vox_pkg::REQ_HIT, 5'd31, 5'd31, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
      send_fields(vox_pkg::REQ_MISS, 5'd31, 5'd31, 3'd7, 32'd5, 16'hFFFF);
      send_fields(vox_pkg::REQ_HIT, 5'd31, 5'd31, 3'd7, 32'd2000, 16'd0);
      send_fields(vox_pkg::REQ_SPARE, 5'd31, 5'd31, 3'd7, 32'd0, 16'd0);
      for (int k = 0; k < 6; k++)
         send_fields(vox_pkg::REQ_HIT, 5'd1, 5'd0, 3'd0, 32'd100 + k * 400, 16'(k));
      send_fields(vox_pkg::REQ_QUERY, 5'd1, 5'd0, 3'd0, 32'd0, 16'd0);
      // A voxel driven into dynamic suspicion: one hit followed by misses.
      send_fields(vox_pkg::REQ_HIT, 5'd2, 5'd3, 3'd4, 32'd10, 16'd7);
      for (int k = 0; k < 4; k++)
         send_fields(vox_pkg::REQ_MISS, 5'd2, 5'd3, 3'd4, 32'd20 + k, 16'd7);
      for (int k = 0; k < 8; k++)
         send_fields(vox_pkg::REQ_MISS, 5'd3, 5'd0, 3'd0, 32'd50, 16'hAAAA);
      drain_block();
   endtask

   // Saturated increments and a floor above the ceiling, where the ceiling wins.
   task automatic test_clamp_extremes();
      write_register(vox_pkg::CSR_HIT_INC, 32'h0000_7FFF);
      write_register(vox_pkg::CSR_MISS_INC, 32'h0000_8000);
      write_register(vox_pkg::CSR_FLOOR, 32'h0000_8000);
      write_register(vox_pkg::CSR_CEILING, 32'h0000_7FFF);
      write_register(vox_pkg::CSR_OCC_THR, 32'h0000_7FFF);
      write_register(vox_pkg::CSR_FREE_THR, 32'h0000_8000);
      write_register(vox_pkg::CSR_MIN_HITS, 32'h0000_FFFF);
      write_register(vox_pkg::CSR_MIN_LIFE, 32'hFFFF_FFFF);
      quiet_mode = 1'b1;
      for (int k = 0; k < 60; k++) random_word(3);
      quiet_mode = 1'b0;
      drain_block();
      write_register(vox_pkg::CSR_FLOOR, 32'h0000_0100);
      write_register(vox_pkg::CSR_CEILING, 32'h0000_FF00);
      write_register(vox_pkg::CSR_MIN_HITS, 32'd0);
      write_register(vox_pkg::CSR_MIN_LIFE, 32'd0);
      for (int k = 0; k < 60; k++) random_word(3);
      drain_block();
   endtask

   // Random settings in each phase, with most words hitting a few voxels.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         write_register(vox_pkg::CSR_HIT_INC, $urandom_range(600));
         write_register(vox_pkg::CSR_MISS_INC, -$urandom_range(600));
         write_register(vox_pkg::CSR_OCC_THR, $urandom_range(512) - 256);
         write_register(vox_pkg::CSR_FREE_THR, -$urandom_range(512));
         write_register(vox_pkg::CSR_FLOOR, -$urandom_range(1200));
         write_register(vox_pkg::CSR_CEILING, $urandom_range(1200));
         write_register(vox_pkg::CSR_MIN_HITS, $urandom_range(6));
         write_register(vox_pkg::CSR_MIN_LIFE,
                        $urandom_range(3) == 0 ? $urandom : $urandom_range(2500));
         if (phase == 2) hold_request = 1'b1;
         for (int k = 0; k < 130; k++) random_word(phase == 5 ? 31 : 7);
         drain_block();
      end
   endtask

   // Result side: random stalls, one long hold-off, and the comparison.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word %h", $time, rsp_word);
               error_count++;
            end else begin
               vox_pkg::rsp_word_type want;
               want = expected_words.pop_front();
               checked_count++;
               if (want !== rsp_word) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_word);
                  error_count++;
               end
            end
         end
         if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_span <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_span > 0) begin
            hold_span <= hold_span - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_mode && ($urandom_range(99) < 20);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_voxel_occupancy_update: done, errors");
            $finish;
         end
      end
   end

   initial begin
      grid_cfg.hit_inc = 16'sd217;
      grid_cfg.miss_inc = -16'sd103;
      grid_cfg.occ_thr = 16'sd0;
      grid_cfg.free_thr = -16'sd256;
      grid_cfg.floor_lo = -16'sd512;
      grid_cfg.ceil_hi = 16'sd896;
      grid_cfg.min_hits = 16'd3;
      grid_cfg.min_life = 32'd1000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_clamp_extremes();
      test_random_traffic();
      drain_block();
      $display("Covered all request codes, clamp and counter extremes and six random");
      $display("settings phases; %0d result words checked, %0d errors.",
               checked_count, error_count);
      if (error_count == 0) begin
         $display("tb_voxel_occupancy_update: done, clean");
      end else begin
         $display("tb_voxel_occupancy_update: done, errors");
      end
      $finish;
   end

endmodule
